>>> rtl/swpsc_pkg.sv
`timescale 1ns / 1ps

package swpsc_pkg;

    // Window storage and value width
    localparam int WINDOW_DEPTH = 32;
    localparam int VALUE_WIDTH  = 48;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int STEP_W       = $clog2(WINDOW_DEPTH);

    // Configuration register
    localparam int                  WLEN_W             = 6;
    localparam logic [WLEN_W-1:0]   WINDOW_LENGTH_INIT = WLEN_W'(25);
    localparam int                  PADDR_W            = 3;
    localparam logic                REG_WINDOW_LENGTH  = 1'b0;

    // Result status codes
    localparam logic [1:0] STATUS_PREAMBLE = 2'd0;
    localparam logic [1:0] STATUS_VALID    = 2'd1;
    localparam logic [1:0] STATUS_INVALID  = 2'd2;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   restart;
    } in_beat_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] echoed_value;
        logic [1:0]             status;
        logic                   first_invalid;
    } out_beat_t;

    // Per-cycle commands broadcast along the chain
    typedef struct packed {
        logic mark;
        logic shift;
        logic rotate;
    } cell_ctrl_t;

endpackage

>>> rtl/sliding_window_pair_sum_check_top.sv
`timescale 1ns / 1ps

// Sliding-window pair-sum checker.
// Input channel s_valid/s_ready/s_data carries one number per beat, with a
// restart bit that empties the window and the first-invalid mark first.
// Result channel m_valid/m_ready/m_data returns one beat per input: the
// number, its status (preamble, valid pair, no pair) and a first-invalid flag.
// The window is a chain of WINDOW_DEPTH cells, newest entry in cell 0.
// A search rotates the whole chain once, one cell per cycle: the entry at the
// head is subtracted from the number and the difference broadcast to every
// cell, which compares it with its own entry. So a searched number passes
// through the SEARCH, PUSH and EMIT states from accept to m_valid, and a
// preamble number through PUSH and EMIT; the next number is taken the cycle
// after the result is loaded into the output register, so a new number is
// not taken until the last one is through.
// window_length is an APB register at address 0 (reset 25).
// Reset (aresetn low, synchronous) empties the window and the output stage.
// A stalled receiver holds the result in the output register while the next
// number is processed; that one waits until the output register is free.

module sliding_window_pair_sum_check_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  swpsc_pkg::in_beat_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output swpsc_pkg::out_beat_t              m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swpsc_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int D  = swpsc_pkg::WINDOW_DEPTH;
    localparam int VW = swpsc_pkg::VALUE_WIDTH;
    localparam int FW = swpsc_pkg::FILL_W;
    localparam int SW = swpsc_pkg::STEP_W;

    typedef enum logic [2:0] {
        IDLE,
        SEARCH,
        PUSH,
        EMIT
    } state_t;

    state_t                           state_reg;
    logic [SW-1:0]                    step_reg;
    logic [FW-1:0]                    fill_reg;
    logic                             invalid_seen_reg;
    logic                             match_reg;
    logic                             preamble_reg;
    logic [VW-1:0]                    value_reg;
    logic [1:0]                       res_status_reg;
    logic                             res_first_reg;
    logic [swpsc_pkg::WLEN_W-1:0]     window_length_reg;
    logic                             m_valid_reg;
    swpsc_pkg::out_beat_t             m_data_reg;

    logic [FW-1:0]                    len_eff;
    logic [FW-1:0]                    fill_eff;
    logic                             accept;
    logic                             cfg_write;
    logic [VW:0]                      diff_full;
    logic                             diff_ok;
    logic [VW-1:0]                    cell_value [D];
    logic [D-1:0]                     cell_flag;
    logic [D-1:0]                     cell_hit;
    logic [D-1:0]                     cell_mark;
    logic                             hit_any;
    logic [1:0]                       status_next;
    swpsc_pkg::cell_ctrl_t            ctrl;

    // Configuration port: always ready, single register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == swpsc_pkg::REG_WINDOW_LENGTH);
    assign prdata    = (paddr[2] == swpsc_pkg::REG_WINDOW_LENGTH)
                       ? {{(32-swpsc_pkg::WLEN_W){1'b0}}, window_length_reg} : 32'd0;

    // Clamp the window length to the usable range
    always_comb begin
        if (window_length_reg < swpsc_pkg::WLEN_W'(2)) begin
            len_eff = FW'(2);
        end else if (int'(window_length_reg) > D) begin
            len_eff = FW'(D);
        end else begin
            len_eff = FW'(window_length_reg);
        end
    end

    assign s_ready  = (state_reg == IDLE);
    assign accept   = s_valid && s_ready;
    assign fill_eff = s_data.restart ? '0 : fill_reg;

    // Chain commands
    assign ctrl.mark   = accept;
    assign ctrl.shift  = (state_reg == PUSH);
    assign ctrl.rotate = (state_reg == SEARCH);

    // Difference of the number and the head entry, broadcast to all cells
    assign diff_full = {1'b0, value_reg} - {1'b0, cell_value[0]};
    assign diff_ok   = cell_flag[0] && !diff_full[VW];

    // Row of cells: push moves toward the tail, rotate moves toward the head
    for (genvar i = 0; i < D; i++) begin : g_cell
        assign cell_mark[i] = (FW'(i) < len_eff);
        swpsc_cell u_cell (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .ctrl            (ctrl),
            .mark_in         (cell_mark[i]),
            .shift_in_value  ((i == 0) ? value_reg : cell_value[(i + D - 1) % D]),
            .rotate_in_value (cell_value[(i + 1) % D]),
            .rotate_in_flag  (cell_flag[(i + 1) % D]),
            .diff            (diff_full[VW-1:0]),
            .diff_ok         (diff_ok),
            .value_out       (cell_value[i]),
            .flag_out        (cell_flag[i]),
            .hit             (cell_hit[i])
        );
    end

    // The head cell holds the subtracted entry itself: drop its match
    assign hit_any = |cell_hit[D-1:1];

    always_comb begin
        if (preamble_reg) begin
            status_next = swpsc_pkg::STATUS_PREAMBLE;
        end else if (match_reg) begin
            status_next = swpsc_pkg::STATUS_VALID;
        end else begin
            status_next = swpsc_pkg::STATUS_INVALID;
        end
    end

    // Sequencer, window bookkeeping and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= IDLE;
            step_reg          <= '0;
            fill_reg          <= '0;
            invalid_seen_reg  <= 1'b0;
            window_length_reg <= swpsc_pkg::WINDOW_LENGTH_INIT;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_write) begin
                window_length_reg <= pwdata[swpsc_pkg::WLEN_W-1:0];
            end
            // Drop a taken result unless the next one is loaded in its place
            if (m_valid_reg && m_ready && (state_reg != EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (accept) begin
                        value_reg    <= s_data.value;
                        fill_reg     <= fill_eff;
                        match_reg    <= 1'b0;
                        step_reg     <= '0;
                        if (s_data.restart) begin
                            invalid_seen_reg <= 1'b0;
                        end
                        if (fill_eff < len_eff) begin
                            preamble_reg <= 1'b1;
                            state_reg    <= PUSH;
                        end else begin
                            preamble_reg <= 1'b0;
                            state_reg    <= SEARCH;
                        end
                    end
                end
                SEARCH: begin
                    match_reg <= match_reg | hit_any;
                    if (step_reg == SW'(D - 1)) begin
                        step_reg  <= '0;
                        state_reg <= PUSH;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                PUSH: begin
                    res_status_reg <= status_next;
                    res_first_reg  <= (status_next == swpsc_pkg::STATUS_INVALID)
                                      && !invalid_seen_reg;
                    if (status_next == swpsc_pkg::STATUS_INVALID) begin
                        invalid_seen_reg <= 1'b1;
                    end
                    if (fill_reg != FW'(D)) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    state_reg <= EMIT;
                end
                EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.echoed_value    <= value_reg;
                        m_data_reg.status          <= res_status_reg;
                        m_data_reg.first_invalid   <= res_first_reg;
                        state_reg                  <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != SEARCH |-> step_reg == '0)
        else $error("search step counter not parked outside a search");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= D)
        else $error("fill count beyond window depth");

    a_restart_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.restart |=> fill_reg == '0 && !invalid_seen_reg)
        else $error("restart did not empty the window");

    a_first_is_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.first_invalid |-> m_data.status == swpsc_pkg::STATUS_INVALID)
        else $error("first-invalid flag on a result that is not invalid");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == swpsc_pkg::STATUS_PREAMBLE
                 || m_data.status == swpsc_pkg::STATUS_VALID
                 || m_data.status == swpsc_pkg::STATUS_INVALID)
        else $error("undefined status code on the result channel");
`endif

endmodule

>>> rtl/swpsc_cell.sv
`timescale 1ns / 1ps

module swpsc_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  swpsc_pkg::cell_ctrl_t              ctrl,
    input  logic                               mark_in,
    input  logic [swpsc_pkg::VALUE_WIDTH-1:0]  shift_in_value,
    input  logic [swpsc_pkg::VALUE_WIDTH-1:0]  rotate_in_value,
    input  logic                               rotate_in_flag,
    input  logic [swpsc_pkg::VALUE_WIDTH-1:0]  diff,
    input  logic                               diff_ok,
    output logic [swpsc_pkg::VALUE_WIDTH-1:0]  value_out,
    output logic                               flag_out,
    output logic                               hit
);

    logic [swpsc_pkg::VALUE_WIDTH-1:0] value_reg;
    logic                              flag_reg;

    // Hold the entry, take a new one on push, pass it round on rotate
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            value_reg <= shift_in_value;
        end else if (ctrl.rotate) begin
            value_reg <= rotate_in_value;
        end
    end

    // Window membership flag travels with the entry during a search
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
        end else begin
            if (ctrl.mark) begin
                flag_reg <= mark_in;
            end else if (ctrl.rotate) begin
                flag_reg <= rotate_in_flag;
            end
        end
    end

    // Match the broadcast difference against this entry
    assign hit       = diff_ok && flag_reg && (value_reg == diff);
    assign value_out = value_reg;
    assign flag_out  = flag_reg;

endmodule
